// ----- rtl/phpr_pkg.sv -----
package phpr_pkg;

   localparam int unsigned PI_Q16 = 205887;

   // register indexes on the csr port
   localparam logic [1:0] CSR_ALPHA   = 2'd0;
   localparam logic [1:0] CSR_EMITTED = 2'd1;

   localparam int RATIO_DIV_W = 32;  // quotient bits of the ratio divider
   localparam int SQRT_STEPS  = 16;
   localparam int Q_DIV_W     = 48;  // quotient bits of both radiance dividers

   // pipeline register indexes
   localparam int ST_IN     = 1;
   localparam int ST_RATIO  = ST_IN + RATIO_DIV_W + 1;
   localparam int ST_PROD   = ST_RATIO + 1;
   localparam int ST_FLUX   = ST_PROD + 1;
   localparam int ST_RADIUS = ST_RATIO + SQRT_STEPS + 1;
   localparam int ST_RSQ    = ST_RADIUS + 1;
   localparam int ST_AREA   = ST_RSQ + 1;
   localparam int ST_Q      = ST_FLUX + Q_DIV_W + 1;
   localparam int ST_RAD    = ST_Q + Q_DIV_W + 1;
   localparam int LAT       = ST_RAD;

   typedef struct packed {
      logic [23:0]            r;
      logic [23:0]            cnt;
      logic                   skip;
      logic [31:0]            e;
      logic [24:0]            rem0;
      logic [31:0]            num_lo;
      logic [24:0]            den;
      logic [31:0]            ratio;
      logic [2:0][31:0]       flux;
      logic [2:0][32:0]       sum;
      logic [2:0][48:0]       p_hi;
      logic [2:0][48:0]       p_lo;
      logic [47:0]            rr;
      logic [33:0]            area;
      logic [2:0][47:0]       q;
      logic [2:0][31:0]       rad;
   } pipe_type;

endpackage

// ----- rtl/phpr_div.sv -----
module phpr_div #(
   parameter int NW = 32,
   parameter int DW = 25
) (
   input  logic          clock,
   input  logic          en,
   input  logic [DW-1:0] rem0,
   input  logic [NW-1:0] num,
   input  logic [DW-1:0] den,
   output logic [NW-1:0] quot
);

   logic [DW-1:0] rem_ff [0:NW-1];
   logic [NW-1:0] nq_ff  [0:NW-1];
   logic [DW-1:0] den_ff [0:NW-1];

   for (genvar k = 0; k < NW; k++) begin : g_step
      logic [DW-1:0] rem_prev;
      logic [NW-1:0] nq_prev;
      logic [DW-1:0] den_prev;
      logic [DW:0]   rem_sh;
      logic [DW+1:0] diff;
      logic          ge;
      logic [DW-1:0] rem_in;
      logic [NW-1:0] nq_in;

      if (k == 0) begin : g_first
         assign rem_prev = rem0;
         assign nq_prev  = num;
         assign den_prev = den;
      end else begin : g_next
         assign rem_prev = rem_ff[k-1];
         assign nq_prev  = nq_ff[k-1];
         assign den_prev = den_ff[k-1];
      end

      // shift in the next numerator bit, subtract if it fits
      assign rem_sh = {rem_prev, nq_prev[NW-1]};
      assign diff   = {1'b0, rem_sh} - {2'b00, den_prev};
      assign ge     = ~diff[DW+1];
      assign rem_in = ge ? diff[DW-1:0] : rem_sh[DW-1:0];
      assign nq_in  = {nq_prev[NW-2:0], ge};

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= rem_in;
            nq_ff[k]  <= nq_in;
            den_ff[k] <= den_prev;
         end
      end
   end

   assign quot = nq_ff[NW-1];

endmodule

// ----- rtl/photon_hit_point_radius_update.sv -----
// channel  direction  transfer when            payload
// req      in         req_valid & req_ready    hit point and photons found this pass
// rsp      out        rsp_valid & rsp_ready    updated hit point and radiance
// csr      in         csr_write_en             alpha (index 0), emitted photons (index 1)
//
// One item enters per cycle while no rsp waits, through 134 register stages; rsp_valid
// is the valid bit of the last one. The depth is set by the chain ratio divider (32 steps),
// flux multiply, and two 48-step radiance dividers in series.
// Reset clears the valid bits and loads the csr defaults.
// A waiting rsp freezes the whole pipeline; req_ready drops only then.
module photon_hit_point_radius_update (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [23:0] req_radius_in,
   input  logic [23:0] req_count_in,
   input  logic [31:0] req_flux_red_in,
   input  logic [31:0] req_flux_green_in,
   input  logic [31:0] req_flux_blue_in,
   input  logic [15:0] req_found_count,
   input  logic [31:0] req_found_red,
   input  logic [31:0] req_found_green,
   input  logic [31:0] req_found_blue,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [23:0] rsp_radius_out,
   output logic [23:0] rsp_count_out,
   output logic [31:0] rsp_flux_red_out,
   output logic [31:0] rsp_flux_green_out,
   output logic [31:0] rsp_flux_blue_out,
   output logic [31:0] rsp_radiance_red,
   output logic [31:0] rsp_radiance_green,
   output logic [31:0] rsp_radiance_blue,
   output logic        rsp_skipped,
   input  logic        csr_write_en,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   import phpr_pkg::*;

   logic [15:0] alpha_ff;
   logic [31:0] emitted_ff;
   logic        en;

   pipe_type side_ff [1:LAT];
   pipe_type side_in [1:LAT];
   logic     vld_ff  [1:LAT];

   logic [31:0] ratio_q;
   logic [47:0] q_quot   [0:2];
   logic [47:0] rad_quot [0:2];

   logic [31:0] sq_v_ff   [1:SQRT_STEPS];
   logic [31:0] sq_res_ff [1:SQRT_STEPS];

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff   <= 16'd45875;
         emitted_ff <= 32'd1000000;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_ALPHA:   alpha_ff   <= csr_wdata[15:0];
            CSR_EMITTED: emitted_ff <= csr_wdata;
            default:     ;
         endcase
      end
   end

   // the whole pipe holds while the output register is full and not taken
   assign en        = ~vld_ff[LAT] | rsp_ready;
   assign req_ready = en;

   // first stage: products, sums, count and divider operands
   always_comb begin
      logic [31:0] am;
      logic [40:0] num_hi;
      logic [24:0] cnt_sum;
      logic        skip;
      am      = alpha_ff * req_found_count;
      num_hi  = {1'b0, req_count_in, 16'd0} + {9'd0, am};
      cnt_sum = {1'b0, req_count_in} + {9'd0, am[31:16]} + 25'd1;
      skip    = (req_found_count == 16'd0);
      side_in[ST_IN]        = '0;
      side_in[ST_IN].r      = req_radius_in;
      side_in[ST_IN].skip   = skip;
      side_in[ST_IN].cnt    = skip ? req_count_in :
                              (cnt_sum[24] ? 24'hFFFFFF : cnt_sum[23:0]);
      side_in[ST_IN].e      = (emitted_ff == 32'd0) ? 32'd1 : emitted_ff;
      side_in[ST_IN].rem0   = num_hi[40:16];
      side_in[ST_IN].num_lo = {am[15:0], 16'd0};
      side_in[ST_IN].den    = skip ? 25'd1 : ({1'b0, req_count_in} + {9'd0, req_found_count});
      side_in[ST_IN].flux   = {req_flux_blue_in, req_flux_green_in, req_flux_red_in};
      side_in[ST_IN].sum[0] = {1'b0, req_flux_red_in} + {1'b0, req_found_red};
      side_in[ST_IN].sum[1] = {1'b0, req_flux_green_in} + {1'b0, req_found_green};
      side_in[ST_IN].sum[2] = {1'b0, req_flux_blue_in} + {1'b0, req_found_blue};
   end

   for (genvar k = ST_IN + 1; k <= LAT; k++) begin : g_stage
      if (k == ST_RATIO) begin : g_ratio
         always_comb begin
            side_in[k]       = side_ff[k-1];
            side_in[k].ratio = ratio_q;
         end
      end else if (k == ST_PROD) begin : g_prod
         always_comb begin
            side_in[k] = side_ff[k-1];
            for (int c = 0; c < 3; c++) begin
               side_in[k].p_hi[c] = side_ff[k-1].sum[c] * side_ff[k-1].ratio[31:16];
               side_in[k].p_lo[c] = side_ff[k-1].sum[c] * side_ff[k-1].ratio[15:0];
            end
         end
      end else if (k == ST_FLUX) begin : g_flux
         always_comb begin
            logic [49:0] fsum;
            side_in[k] = side_ff[k-1];
            for (int c = 0; c < 3; c++) begin
               fsum = {1'b0, side_ff[k-1].p_hi[c]} + {17'd0, side_ff[k-1].p_lo[c][48:16]};
               if (!side_ff[k-1].skip)
                  side_in[k].flux[c] = (|fsum[49:48]) ? 32'hFFFFFFFF : fsum[47:16];
            end
         end
      end else if (k == ST_RADIUS) begin : g_radius
         always_comb begin
            logic [39:0] rm;
            rm         = side_ff[k-1].r * sq_res_ff[SQRT_STEPS][15:0];
            side_in[k] = side_ff[k-1];
            if (!side_ff[k-1].skip)
               side_in[k].r = rm[39:16];
         end
      end else if (k == ST_RSQ) begin : g_rsq
         always_comb begin
            side_in[k]    = side_ff[k-1];
            side_in[k].rr = side_ff[k-1].r * side_ff[k-1].r;
         end
      end else if (k == ST_AREA) begin : g_area
         always_comb begin
            logic [65:0] ap;
            ap              = {18'd0, side_ff[k-1].rr} * 66'(PI_Q16);
            side_in[k]      = side_ff[k-1];
            side_in[k].area = ap[65:32];
         end
      end else if (k == ST_Q) begin : g_q
         always_comb begin
            side_in[k] = side_ff[k-1];
            for (int c = 0; c < 3; c++)
               side_in[k].q[c] = q_quot[c];
         end
      end else if (k == ST_RAD) begin : g_rad
         always_comb begin
            side_in[k] = side_ff[k-1];
            for (int c = 0; c < 3; c++) begin
               if (side_ff[k-1].area == 34'd0)
                  side_in[k].rad[c] = (side_ff[k-1].q[c] != 48'd0) ? 32'hFFFFFFFF : 32'd0;
               else
                  side_in[k].rad[c] = (|rad_quot[c][47:32]) ? 32'hFFFFFFFF : rad_quot[c][31:0];
            end
         end
      end else begin : g_pass
         assign side_in[k] = side_ff[k-1];
      end
   end

   for (genvar k = 1; k <= LAT; k++) begin : g_regs
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= (k == 1) ? req_valid : vld_ff[(k == 1) ? 1 : k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            side_ff[k] <= side_in[k];
         end
      end
   end

   // ratio = (N*2^16 + alpha*M) * 2^16 / (N + M)
   phpr_div #(.NW(RATIO_DIV_W), .DW(25)) u_ratio_div (
      .clock (clock),
      .en    (en),
      .rem0  (side_ff[ST_IN].rem0),
      .num   (side_ff[ST_IN].num_lo),
      .den   (side_ff[ST_IN].den),
      .quot  (ratio_q)
   );

   // square root of the ratio, one result bit per stage
   for (genvar j = 1; j <= SQRT_STEPS; j++) begin : g_sqrt
      localparam logic [31:0] SQ_BIT = 32'd1 << (32 - 2 * j);
      logic [31:0] v_prev;
      logic [31:0] res_prev;
      logic [31:0] t;
      logic        ge;

      if (j == 1) begin : g_first
         assign v_prev   = side_ff[ST_RATIO].ratio;
         assign res_prev = 32'd0;
      end else begin : g_next
         assign v_prev   = sq_v_ff[j-1];
         assign res_prev = sq_res_ff[j-1];
      end

      assign t  = res_prev + SQ_BIT;
      assign ge = (v_prev >= t);

      always_ff @(posedge clock) begin
         if (en) begin
            sq_v_ff[j]   <= ge ? (v_prev - t) : v_prev;
            sq_res_ff[j] <= ge ? ((res_prev >> 1) + SQ_BIT) : (res_prev >> 1);
         end
      end
   end

   for (genvar c = 0; c < 3; c++) begin : g_chan
      phpr_div #(.NW(Q_DIV_W), .DW(32)) u_q_div (
         .clock (clock),
         .en    (en),
         .rem0  (32'd0),
         .num   ({side_ff[ST_FLUX].flux[c], 16'd0}),
         .den   (side_ff[ST_FLUX].e),
         .quot  (q_quot[c])
      );

      phpr_div #(.NW(Q_DIV_W), .DW(34)) u_rad_div (
         .clock (clock),
         .en    (en),
         .rem0  (34'd0),
         .num   (side_ff[ST_Q].q[c]),
         .den   ((side_ff[ST_Q].area == 34'd0) ? 34'd1 : side_ff[ST_Q].area),
         .quot  (rad_quot[c])
      );
   end

   assign rsp_valid          = vld_ff[LAT];
   assign rsp_radius_out     = side_ff[LAT].r;
   assign rsp_count_out      = side_ff[LAT].cnt;
   assign rsp_flux_red_out   = side_ff[LAT].flux[0];
   assign rsp_flux_green_out = side_ff[LAT].flux[1];
   assign rsp_flux_blue_out  = side_ff[LAT].flux[2];
   assign rsp_radiance_red   = side_ff[LAT].rad[0];
   assign rsp_radiance_green = side_ff[LAT].rad[1];
   assign rsp_radiance_blue  = side_ff[LAT].rad[2];
   assign rsp_skipped        = side_ff[LAT].skip;

endmodule

// ----- tb/photon_hit_point_radius_update_test.sv -----
module photon_hit_point_radius_update_test;
   import phpr_pkg::*;

   localparam logic [63:0] MAX24 = 64'hFFFFFF;
   localparam logic [63:0] MAX32 = 64'hFFFFFFFF;

   typedef struct {
      logic [23:0] radius;
      logic [23:0] count;
      logic [31:0] flux [3];
      logic [15:0] found_n;
      logic [31:0] found_e [3];
   } hit_type;

   typedef struct {
      logic [23:0] radius;
      logic [23:0] count;
      logic [31:0] flux [3];
      logic [31:0] radiance [3];
      logic        skipped;
   } update_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   logic [23:0] req_radius_in = 0;
   logic [23:0] req_count_in = 0;
   logic [31:0] req_flux_red_in = 0;
   logic [31:0] req_flux_green_in = 0;
   logic [31:0] req_flux_blue_in = 0;
   logic [15:0] req_found_count = 0;
   logic [31:0] req_found_red = 0;
   logic [31:0] req_found_green = 0;
   logic [31:0] req_found_blue = 0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic [23:0] rsp_radius_out;
   logic [23:0] rsp_count_out;
   logic [31:0] rsp_flux_red_out;
   logic [31:0] rsp_flux_green_out;
   logic [31:0] rsp_flux_blue_out;
   logic [31:0] rsp_radiance_red;
   logic [31:0] rsp_radiance_green;
   logic [31:0] rsp_radiance_blue;
   logic        rsp_skipped;
   logic        csr_write_en = 0;
   logic [1:0]  csr_index = 0;
   logic [31:0] csr_wdata = 0;

   photon_hit_point_radius_update i_dut (.*);

   always #1 clock = ~clock;

   // local copy of the registers
   logic [15:0] alpha_q = 16'd45875;
   logic [31:0] emitted_q = 32'd1000000;

   hit_type    pending_hits [$];
   update_type expected_updates [$];
   hit_type    driven_hit;
   int      errors = 0;
   int      accepted = 0;
   int      checked = 0;
   int      skipped_seen = 0;

   function automatic logic [63:0] mul_q32(logic [63:0] a, logic [63:0] b);
      return (a * b[31:16] + ((a * b[15:0]) >> 16)) >> 16;
   endfunction

   function automatic logic [63:0] int_sqrt(logic [63:0] v);
      logic [63:0] res, bitv;
      res = 0;
      bitv = 64'd1 << 30;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic logic [31:0] radiance_est(logic [63:0] flux, logic [63:0] r);
      logic [63:0] e, area, q, rad;
      e = (emitted_q == 0) ? 64'd1 : 64'(emitted_q);
      area = mul_q32(r * r, 64'(PI_Q16));
      q = (flux << 16) / e;
      if (area == 0) return (q != 0) ? 32'hFFFFFFFF : 32'd0;
      rad = q / area;
      return (rad > MAX32) ? 32'hFFFFFFFF : rad[31:0];
   endfunction

   function automatic update_type predict_update(hit_type h);
      update_type u;
      logic [63:0] n, m, a, ratio, sroot, cnt, f;
      n = 64'(h.count);
      m = 64'(h.found_n);
      a = 64'(alpha_q);
      u.skipped = (m == 0);
      if (m == 0) begin
         u.radius = h.radius;
         u.count = h.count;
         for (int c = 0; c < 3; c++) begin
            u.flux[c] = h.flux[c];
            u.radiance[c] = radiance_est(64'(h.flux[c]), 64'(h.radius));
         end
      end else begin
         ratio = (((n << 16) + a * m) << 16) / (n + m);
         if (ratio > MAX32) ratio = MAX32;
         sroot = int_sqrt(ratio);
         u.radius = 24'((64'(h.radius) * sroot) >> 16);
         cnt = n + ((m * a) >> 16) + 1;
         u.count = (cnt > MAX24) ? 24'hFFFFFF : cnt[23:0];
         for (int c = 0; c < 3; c++) begin
            f = mul_q32(64'(h.flux[c]) + 64'(h.found_e[c]), ratio);
            if (f > MAX32) f = MAX32;
            u.flux[c] = f[31:0];
            u.radiance[c] = radiance_est(f, 64'(u.radius));
         end
      end
      return u;
   endfunction

   // sender: bursts of random length with random gaps
   int burst_left = 0;
   int gap_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 0;
      end else begin
         if (req_valid && req_ready) begin
            expected_updates.push_back(predict_update(driven_hit));
            accepted++;
         end
         if (!(req_valid && !req_ready)) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 0;
            end else if (pending_hits.size() > 0) begin
               driven_hit = pending_hits.pop_front();
               req_radius_in <= driven_hit.radius;
               req_count_in <= driven_hit.count;
               req_flux_red_in <= driven_hit.flux[0];
               req_flux_green_in <= driven_hit.flux[1];
               req_flux_blue_in <= driven_hit.flux[2];
               req_found_count <= driven_hit.found_n;
               req_found_red <= driven_hit.found_e[0];
               req_found_green <= driven_hit.found_e[1];
               req_found_blue <= driven_hit.found_e[2];
               req_valid <= 1;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(40, 1);
                  gap_left = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
               end
            end else begin
               req_valid <= 0;
            end
         end
      end
   end

   task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
         errors++;
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
      end
   endtask

   // receiver: stall pattern switches between modes
   int stall_mode = 0;
   int mode_left = 0;
   always @(posedge clock) begin
      update_type e;
      if (reset) begin
         rsp_ready <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_updates.size() == 0) begin
               errors++;
               $display("%0t: unexpected transfer, expected none, actual radius %h",
                        $time, rsp_radius_out);
            end else begin
               e = expected_updates.pop_front();
               checked++;
               if (e.skipped) skipped_seen++;
               check_field("radius", 32'(e.radius), 32'(rsp_radius_out));
               check_field("count", 32'(e.count), 32'(rsp_count_out));
               check_field("flux_red", e.flux[0], rsp_flux_red_out);
               check_field("flux_green", e.flux[1], rsp_flux_green_out);
               check_field("flux_blue", e.flux[2], rsp_flux_blue_out);
               check_field("radiance_red", e.radiance[0], rsp_radiance_red);
               check_field("radiance_green", e.radiance[1], rsp_radiance_green);
               check_field("radiance_blue", e.radiance[2], rsp_radiance_blue);
               check_field("skipped", 32'(e.skipped), 32'(rsp_skipped));
            end
         end
         if (mode_left == 0) begin
            stall_mode = $urandom_range(3, 0);
            mode_left = $urandom_range(200, 20);
         end else begin
            mode_left--;
         end
         case (stall_mode)
            0: rsp_ready <= 1;
            1: rsp_ready <= ($urandom_range(1, 0) == 1);
            2: rsp_ready <= ($urandom_range(7, 0) == 0);
            default: rsp_ready <= (mode_left % 5 != 0);
         endcase
      end
   end

   function automatic hit_type make_hit(logic [23:0] r, logic [23:0] n, logic [31:0] f,
                                        logic [15:0] m, logic [31:0] e);
      hit_type h;
      h.radius = r;
      h.count = n;
      h.found_n = m;
      for (int c = 0; c < 3; c++) begin
         h.flux[c] = f;
         h.found_e[c] = e;
      end
      return h;
   endfunction

   function automatic hit_type random_hit();
      hit_type h;
      int sel;
      sel = $urandom_range(7, 0);
      h.radius = (sel == 1) ? 24'($urandom_range(255, 0)) : 24'($urandom);
      h.count = (sel == 2) ? 24'($urandom_range(100, 0)) : 24'($urandom);
      h.found_n = (sel == 0) ? 16'd0 : 16'($urandom);
      for (int c = 0; c < 3; c++) begin
         h.flux[c] = (sel == 3) ? 32'($urandom_range(65535, 0)) : $urandom;
         h.found_e[c] = $urandom;
      end
      return h;
   endfunction

   task automatic write_reg(logic [1:0] idx, logic [31:0] val);
      @(posedge clock);
      csr_write_en <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_write_en <= 0;
      if (idx == CSR_ALPHA) alpha_q = val[15:0];
      else if (idx == CSR_EMITTED) emitted_q = val;
   endtask

   task automatic wait_idle();
      do @(posedge clock);
      while (pending_hits.size() != 0 || req_valid || expected_updates.size() != 0);
      repeat (LAT + 10) @(posedge clock);
   endtask

   task automatic run_random(int count);
      repeat (count) pending_hits.push_back(random_hit());
      wait_idle();
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 0;
      // directed: pass-through, zero area, saturation of count and flux
      pending_hits.push_back(make_hit(24'h010000, 24'd100, 32'h00010000, 16'd0, 32'd5));
      pending_hits.push_back(make_hit(24'd0, 24'd0, 32'hFFFFFFFF, 16'd0, 32'd0));
      pending_hits.push_back(make_hit(24'd0, 24'd0, 32'd0, 16'd0, 32'd0));
      pending_hits.push_back(make_hit(24'd0, 24'd5, 32'd7, 16'd3, 32'd9));
      pending_hits.push_back(make_hit(24'hFFFFFF, 24'hFFFFFF, 32'hFFFFFFFF, 16'hFFFF,
                                      32'hFFFFFFFF));
      pending_hits.push_back(make_hit(24'hFFFFFF, 24'd0, 32'd0, 16'd1, 32'hFFFFFFFF));
      pending_hits.push_back(make_hit(24'h000001, 24'd0, 32'd1, 16'hFFFF, 32'd0));
      pending_hits.push_back(make_hit(24'h080000, 24'hFFFFF0, 32'h12345678, 16'h8000,
                                      32'h87654321));
      pending_hits.push_back(make_hit(24'h000100, 24'd1, 32'hFFFFFFFF, 16'd1, 32'hFFFFFFFF));
      pending_hits.push_back(make_hit(24'hFFFFFF, 24'hFFFFFF, 32'h00000001, 16'd0, 32'd1));
      wait_idle();
      // zero alpha, single emitted photon
      write_reg(CSR_ALPHA, 32'd0);
      write_reg(CSR_EMITTED, 32'd1);
      pending_hits.push_back(make_hit(24'h010000, 24'd10, 32'h00100000, 16'd10, 32'h1000));
      pending_hits.push_back(make_hit(24'h000010, 24'd0, 32'hFFFFFFFF, 16'd4, 32'hFFFFFFFF));
      run_random(100);
      // extremes: alpha max, emitted max
      write_reg(CSR_ALPHA, 32'hFFFF);
      write_reg(CSR_EMITTED, 32'hFFFFFFFF);
      pending_hits.push_back(make_hit(24'hFFFFFF, 24'hFFFFFF, 32'hFFFFFFFF, 16'hFFFF,
                                      32'hFFFFFFFF));
      run_random(100);
      // emitted zero acts as one; smallest nonzero alpha
      write_reg(CSR_ALPHA, 32'd1);
      write_reg(CSR_EMITTED, 32'd0);
      pending_hits.push_back(make_hit(24'h000200, 24'd3, 32'h00020000, 16'd0, 32'd0));
      run_random(100);
      // out-of-range indexes must leave the registers alone
      write_reg(2'd2, $urandom);
      write_reg(2'd3, $urandom);
      run_random(60);
      repeat (2) begin
         write_reg(CSR_ALPHA, $urandom);
         write_reg(CSR_EMITTED, $urandom);
         run_random(80);
      end
      $display("checked %0d updates of %0d hit points, %0d of them pass-through,",
               checked, accepted, skipped_seen);
      $display("over reset, zero, extreme and random register settings");
      if (errors == 0 && expected_updates.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("FAIL");
      $finish;
   end

endmodule
